// File: rtl/frt_pkg.sv
// frt_pkg: shared types, widths, codes and reset values for the fragment
// reassembly tracker. No dependencies; imported by every module of the block.
`default_nettype none

package frt_pkg;

   // slot table size default
   localparam int SLOTS_DEF = 8;

   // field widths
   localparam int ID_W       = 16;
   localparam int OFF_W      = 13;
   localparam int LEN_W      = 16;
   localparam int TIME_W     = 32;
   localparam int TTL_W      = 16;
   localparam int BYTES_W    = 17;
   localparam int RECV_W     = 20;
   localparam int SLOT_OUT_W = 3;
   localparam int WOFF_W     = 16;

   // stream and csr port widths
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register reset values and limits
   localparam logic [TTL_W-1:0]   TTL_RESET       = 16'd5;
   localparam logic [BYTES_W-1:0] MAX_BYTES_RESET = 17'h10000;
   localparam logic [RECV_W-1:0]  RECV_MAX        = 20'hFFFFF;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_PENDING  = 2'd0,
      STATUS_COMPLETE = 2'd1,
      STATUS_NO_SPACE = 2'd2
   } status_type;

   // register index codes (byte address 4 * index)
   typedef enum logic {
      REG_TTL       = 1'b0,
      REG_MAX_BYTES = 1'b1
   } reg_index_type;

   // one fragment header
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [OFF_W-1:0]  offset;
      logic              last;
      logic [LEN_W-1:0]  len;
      logic [TIME_W-1:0] now;
   } frag_type;

   // one result
   typedef struct packed {
      status_type             status;
      logic [SLOT_OUT_W-1:0]  slot;
      logic                   accepted;
      logic [WOFF_W-1:0]      write_offset;
      logic [BYTES_W-1:0]     total_length;
   } result_type;

   // configuration seen by the slot table
   typedef struct packed {
      logic [TTL_W-1:0]   ttl;
      logic [BYTES_W-1:0] max_bytes;
   } csr_type;

endpackage

`default_nettype wire

// File: rtl/frt_slot_table.sv
// frt_slot_table: slot state, parallel id match, lowest free or aged slot
// claim and per-fragment update. Depends on frt_pkg.
`default_nettype none

module frt_slot_table
   import frt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire frag_type   frag,
   input  wire csr_type    csr,
   output result_type      result
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // slot state
   logic [SLOTS-1:0]  busy_ff;
   logic [ID_W-1:0]   ident_ff    [SLOTS];
   logic [TIME_W-1:0] stamp_ff    [SLOTS];
   logic [RECV_W-1:0] received_ff [SLOTS];
   logic [BYTES_W-1:0] needed_ff  [SLOTS];

   logic [SLOTS-1:0]  match_vec;
   logic [SLOTS-1:0]  free_vec;

   logic [IDX_W-1:0]  match_idx;
   logic [IDX_W-1:0]  claim_idx;
   logic [IDX_W-1:0]  sel_idx;
   logic              hit;
   logic              claimed;
   logic              use_slot;

   logic [RECV_W-1:0]  recv_old;
   logic [BYTES_W-1:0] needed_old;
   logic [WOFF_W-1:0]  dst;
   logic [BYTES_W-1:0] frag_end;
   logic               accepted;
   logic [RECV_W:0]    recv_sum;
   logic [RECV_W-1:0]  recv_new;
   logic [BYTES_W-1:0] needed_new;
   logic               complete;
   logic [IDX_W+SLOT_OUT_W-1:0] idx_ext;

   // per-slot id match and reclaim test
   for (genvar i = 0; i < SLOTS; i++) begin : g_lane
      logic [TIME_W-1:0] age;
      assign age          = frag.now - stamp_ff[i];
      assign match_vec[i] = busy_ff[i] && (ident_ff[i] == frag.id);
      assign free_vec[i]  = !busy_ff[i] ||
                            (age > {{(TIME_W-TTL_W){1'b0}}, csr.ttl});
   end

   // lowest matching slot and lowest claimable slot
   always_comb begin
      match_idx = '0;
      claim_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (match_vec[i]) match_idx = IDX_W'(i);
         if (free_vec[i])  claim_idx = IDX_W'(i);
      end
   end

   assign hit      = |match_vec;
   assign claimed  = !hit && (|free_vec);
   assign use_slot = hit || claimed;
   assign sel_idx  = hit ? match_idx : claim_idx;

   // a freshly claimed slot starts with zero counts
   assign recv_old   = claimed ? '0 : received_ff[sel_idx];
   assign needed_old = claimed ? '0 : needed_ff[sel_idx];

   // byte offset, fragment end and fit check
   assign dst      = {frag.offset, 3'b000};
   assign frag_end = {1'b0, dst} + {1'b0, frag.len};
   assign accepted = frag_end < csr.max_bytes;

   // saturating received count
   assign recv_sum = {1'b0, recv_old} + {{(RECV_W+1-LEN_W){1'b0}}, frag.len};
   always_comb begin
      priority if (!accepted)           recv_new = recv_old;
      else if (recv_sum[RECV_W])        recv_new = RECV_MAX;
      else                              recv_new = recv_sum[RECV_W-1:0];
   end

   assign needed_new = frag.last ? frag_end : needed_old;
   assign complete   = (needed_new != '0) &&
                       ({{(RECV_W-BYTES_W){1'b0}}, needed_new} <= recv_new);

   assign idx_ext = (IDX_W+SLOT_OUT_W)'(sel_idx);

   // result of this fragment
   always_comb begin
      if (!use_slot) begin
         result.status       = STATUS_NO_SPACE;
         result.slot         = '0;
         result.accepted     = 1'b0;
         result.write_offset = '0;
         result.total_length = '0;
      end else begin
         result.status       = complete ? STATUS_COMPLETE : STATUS_PENDING;
         result.slot         = idx_ext[SLOT_OUT_W-1:0];
         result.accepted     = accepted;
         result.write_offset = dst;
         result.total_length = complete ? needed_new : '0;
      end
   end

   // busy flags
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (fire && use_slot) begin
         busy_ff[sel_idx] <= !complete;
      end
   end

   // slot payload
   always_ff @(posedge clock) begin
      if (fire && use_slot) begin
         received_ff[sel_idx] <= recv_new;
         needed_ff[sel_idx]   <= needed_new;
         if (claimed) begin
            ident_ff[sel_idx] <= frag.id;
            stamp_ff[sel_idx] <= frag.now;
         end
      end
   end

`ifndef SYNTHESIS
   // busy slots never share an id
   a_unique_id: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("two busy slots hold the same id");

   // a completed slot is released
   a_complete_frees: assert property (@(posedge clock) disable iff (reset)
      fire && use_slot && complete |=> !busy_ff[$past(sel_idx)])
      else $error("completed slot still busy");

   // a pending slot stays busy
   a_pending_holds: assert property (@(posedge clock) disable iff (reset)
      fire && use_slot && !complete |=> busy_ff[$past(sel_idx)])
      else $error("pending slot not busy");

   // no space leaves the table untouched
   a_no_space_stable: assert property (@(posedge clock) disable iff (reset)
      fire && !use_slot |=> busy_ff == $past(busy_ff))
      else $error("table changed on no space");
`endif

endmodule

`default_nettype wire

// File: rtl/fragment_reassembly_tracker.sv
// fragment_reassembly_tracker: an input transfer reaches its result on rsp_*
// through one input register, then one pass through the slot table into the
// result register. Throughput is one fragment per cycle while rsp_tready lets
// the result register drain, set by the match, claim and update of the slot table.
// Reset frees every slot and loads ttl_seconds = 5, max_bytes = 65536; there is
// no clearing pass, the block accepts transfers right after reset.
// Depends on frt_pkg and frt_slot_table.
`default_nettype none

module fragment_reassembly_tracker
   import frt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // fragment header stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // frag_id[15:0], frag_offset[28:16], payload_len[44:29],
   // now_seconds[76:45], zero[79:77]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tlast,   // last_flag
   // result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // slot[2:0], accepted[3], write_offset[19:4], total_length[36:20],
   // zero[39:37]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic [RSP_USER_W-1:0]      rsp_tuser,   // status[1:0]
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   logic               in_valid_ff;
   frag_type           in_frag_ff;
   frag_type           frag_in;
   logic               rsp_valid_ff;
   result_type         rsp_result_ff;
   result_type         result;
   logic               fire;
   logic [TTL_W-1:0]   ttl_ff;
   logic [BYTES_W-1:0] max_bytes_ff;
   csr_type            csr;
   reg_index_type      reg_sel;
   logic               csr_write;

   // configuration registers
   assign csr_pready = 1'b1;
   assign reg_sel    = reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff       <= TTL_RESET;
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_write) begin
         unique case (reg_sel)
            REG_TTL:       ttl_ff       <= csr_pwdata[TTL_W-1:0];
            REG_MAX_BYTES: max_bytes_ff <= csr_pwdata[BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_TTL:       csr_prdata = {{(CSR_DATA_W-TTL_W){1'b0}}, ttl_ff};
         REG_MAX_BYTES: csr_prdata = {{(CSR_DATA_W-BYTES_W){1'b0}}, max_bytes_ff};
         default:       csr_prdata = '0;
      endcase
   end

   assign csr.ttl       = ttl_ff;
   assign csr.max_bytes = max_bytes_ff;

   // input unpacking
   assign frag_in.id     = req_tdata[15:0];
   assign frag_in.offset = req_tdata[28:16];
   assign frag_in.last   = req_tlast;
   assign frag_in.len    = req_tdata[44:29];
   assign frag_in.now    = req_tdata[76:45];

   // handshake: the slot table runs when the result register can take a result
   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_frag_ff <= frag_in;
      end
   end

   // slot table
   frt_slot_table #(
      .SLOTS (SLOTS)
   ) u_slot_table (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .frag   (in_frag_ff),
      .csr    (csr),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_result_ff <= result;
      end
   end

   // output packing
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.status;
   assign rsp_tdata  = {3'b000,
                        rsp_result_ff.total_length,
                        rsp_result_ff.write_offset,
                        rsp_result_ff.accepted,
                        rsp_result_ff.slot};

endmodule

`default_nettype wire

// File: test/tb_fragment_reassembly_tracker.sv
// tb_fragment_reassembly_tracker: self-checking bench for the fragment reassembly
// tracker; drives fragment headers over the req_ stream, checks every rsp_ result.
// Depends on frt_pkg and fragment_reassembly_tracker.
`default_nettype none

module tb_fragment_reassembly_tracker;
   import frt_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 315;
   localparam int PHASE_COUNT  = 6;
   localparam int MAX_PRINTS   = 40;
   localparam int FLOOD_FRAGS  = 17;

   // receiver back-pressure patterns
   typedef enum logic [1:0] {
      RX_STREAM = 2'd0,
      RX_THIRDS = 2'd1,
      RX_COIN   = 2'd2,
      RX_HOLD   = 2'd3
   } rx_mode_type;

   // one row of the directed table; want is used only when pinned
   typedef struct packed {
      frag_type   hdr;
      logic       pinned;
      result_type want;
   } directed_row_type;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tlast   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fragment_reassembly_tracker dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted slot table and register copies
   logic              in_use       [SLOTS_DEF] = '{default: 1'b0};
   logic [ID_W-1:0]   owner_id     [SLOTS_DEF] = '{default: '0};
   logic [TIME_W-1:0] start_stamp  [SLOTS_DEF] = '{default: '0};
   logic [RECV_W-1:0] bytes_seen   [SLOTS_DEF] = '{default: '0};
   logic [BYTES_W-1:0] bytes_needed [SLOTS_DEF] = '{default: '0};
   logic [TTL_W-1:0]   ttl_limit   = TTL_RESET;
   logic [BYTES_W-1:0] buffer_size = MAX_BYTES_RESET;

   result_type  fragment_outcomes [$];
   result_type  seen_result;
   result_type  due_result;
   int          error_count    = 0;
   int          headers_sent   = 0;
   int          results_seen   = 0;
   int          completions    = 0;
   int          no_space_count = 0;
   int          rejected_count = 0;
   int          settings_used  = 1;
   int          burst_left     = 0;
   int          rx_left        = 0;
   int          rx_tick        = 0;
   rx_mode_type rx_mode        = RX_STREAM;
   int unsigned cycle_count    = 0;
   logic [TIME_W-1:0] wall_seconds = '0;

   // directed table: reset values ttl 5, max_bytes 65536
   directed_row_type directed_rows [16] = '{
      // first fragment of a fresh packet lands in slot 0
      '{'{16'h0001, 13'd0, 1'b0, 16'd100, 32'd1000}, 1'b1,
        '{STATUS_PENDING, 3'd0, 1'b1, 16'd0, 17'd0}},
      // last fragment covers the rest: complete, slot freed
      '{'{16'h0001, 13'd12, 1'b1, 16'd50, 32'd1001}, 1'b1,
        '{STATUS_COMPLETE, 3'd0, 1'b1, 16'd96, 17'd146}},
      // all fields at their top: payload rejected, needed still set
      '{'{16'hFFFF, 13'h1FFF, 1'b1, 16'hFFFF, 32'hFFFF_FFFF}, 1'b1,
        '{STATUS_PENDING, 3'd0, 1'b0, 16'd65528, 17'd0}},
      // zero-length last fragment at offset zero: needed stays zero
      '{'{16'h0000, 13'd0, 1'b1, 16'd0, 32'd0}, 1'b1,
        '{STATUS_PENDING, 3'd1, 1'b1, 16'd0, 17'd0}},
      // fill the remaining slots
      '{'{16'h0010, 13'd0, 1'b0, 16'd8, 32'd0}, 1'b0, '0},
      '{'{16'h0011, 13'd0, 1'b0, 16'd8, 32'd0}, 1'b0, '0},
      '{'{16'h0012, 13'd0, 1'b0, 16'd8, 32'd0}, 1'b0, '0},
      '{'{16'h0013, 13'd0, 1'b0, 16'd8, 32'd0}, 1'b0, '0},
      '{'{16'h0014, 13'd0, 1'b0, 16'd8, 32'd0}, 1'b0, '0},
      '{'{16'h0015, 13'd0, 1'b0, 16'd8, 32'd0}, 1'b0, '0},
      // table full, ages within ttl (one across the time wrap): no space
      '{'{16'h1234, 13'd0, 1'b0, 16'd8, 32'd3}, 1'b1,
        '{STATUS_NO_SPACE, 3'd0, 1'b0, 16'd0, 17'd0}},
      // id match wins although the slot is past its ttl
      '{'{16'h0000, 13'd1, 1'b0, 16'd8, 32'd100}, 1'b0, '0},
      // stale slot reclaimed by age
      '{'{16'h2222, 13'd0, 1'b1, 16'd20, 32'd100}, 1'b0, '0},
      // end one below max_bytes is accepted, end equal to it is not
      '{'{16'h3333, 13'h1FFF, 1'b0, 16'd7, 32'd100}, 1'b0, '0},
      '{'{16'h3333, 13'h1FFF, 1'b1, 16'd8, 32'd100}, 1'b0, '0},
      '{'{16'h3333, 13'd0, 1'b0, 16'hFFFF, 32'd101}, 1'b0, '0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // match, claim and update of the slot table for one header
   function automatic result_type track_fragment(input frag_type hdr);
      result_type        res;
      int                hit;
      int                k;
      logic [TIME_W-1:0] age;
      logic [17:0]       frag_end;
      logic [20:0]       sum;
      res = '0;
      res.status = STATUS_PENDING;
      hit = -1;
      for (k = 0; k < SLOTS_DEF; k++)
         if (hit < 0 && in_use[k] && owner_id[k] == hdr.id) hit = k;
      for (k = 0; k < SLOTS_DEF; k++) begin
         age = hdr.now - start_stamp[k];
         if (hit < 0 && (!in_use[k] || age > TIME_W'(ttl_limit))) begin
            hit = k;
            in_use[k] = 1'b1;
            start_stamp[k] = hdr.now;
            owner_id[k] = hdr.id;
            bytes_seen[k] = '0;
            bytes_needed[k] = '0;
         end
      end
      if (hit < 0) begin
         res.status = STATUS_NO_SPACE;
      end else begin
         frag_end = {2'b00, hdr.offset, 3'b000} + 18'(hdr.len);
         res.slot = SLOT_OUT_W'(hit);
         res.write_offset = {hdr.offset, 3'b000};
         if (frag_end < 18'(buffer_size)) begin
            res.accepted = 1'b1;
            sum = 21'(bytes_seen[hit]) + 21'(hdr.len);
            bytes_seen[hit] = (sum > 21'(RECV_MAX)) ? RECV_MAX : sum[RECV_W-1:0];
         end
         if (hdr.last) bytes_needed[hit] = frag_end[BYTES_W-1:0];
         if (bytes_needed[hit] != '0 && RECV_W'(bytes_needed[hit]) <= bytes_seen[hit]) begin
            res.status = STATUS_COMPLETE;
            res.total_length = bytes_needed[hit];
            in_use[hit] = 1'b0;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < MAX_PRINTS)
         $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // one header transfer; sender runs in bursts with idle gaps between them
   task automatic send_frag(input frag_type hdr, input logic pinned, input result_type want);
      int         gap;
      result_type predicted;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, hdr.now, hdr.len, hdr.offset, hdr.id};
      req_tlast  <= hdr.last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predicted = track_fragment(hdr);
      fragment_outcomes.push_back(pinned ? want : predicted);
      burst_left--;
      headers_sent++;
   endtask

   // wait for all results, then let the pipeline empty out
   task automatic settle();
      req_tvalid <= 1'b0;
      while (fragment_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write: setup cycle, access cycle, then the bus goes idle
   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_TTL:       ttl_limit   = value[TTL_W-1:0];
         REG_MAX_BYTES: buffer_size = value[BYTES_W-1:0];
      endcase
      @(posedge clock);
   endtask

   // mostly whole packets from a small id pool, some broken, some noise
   task automatic run_traffic(input int budget);
      frag_type pkt [$];
      frag_type hdr;
      frag_type tmp;
      int       sent_here;
      int       pick;
      int       nfrag;
      int       unit;
      int       step;
      int       k;
      int       a;
      int       b;
      logic     big;
      logic [ID_W-1:0] id_base;
      sent_here = 0;
      id_base = ID_W'($urandom());
      while (sent_here < budget) begin
         pick = $urandom_range(0, 99);
         pkt.delete();
         if (pick < 12) begin
            // noise header
            hdr.id = ID_W'($urandom());
            hdr.offset = OFF_W'($urandom());
            hdr.last = 1'($urandom_range(0, 1));
            hdr.len = LEN_W'($urandom());
            hdr.now = ($urandom_range(0, 1) != 0) ? TIME_W'($urandom()) : wall_seconds;
            pkt.push_back(hdr);
         end else if (pick < 14 && buffer_size > 17'd65535) begin
            // full-size payloads until the received count saturates, then the last one
            hdr.id = id_base + ID_W'($urandom_range(0, 11));
            hdr.offset = '0;
            hdr.last = 1'b0;
            hdr.len = 16'hFFFF;
            hdr.now = wall_seconds;
            for (k = 0; k < FLOOD_FRAGS; k++) pkt.push_back(hdr);
            hdr.last = 1'b1;
            hdr.len = 16'd100;
            pkt.push_back(hdr);
         end else begin
            // one packet split into fragments at 8-byte boundaries
            hdr.id = id_base + ID_W'($urandom_range(0, 11));
            nfrag = $urandom_range(1, 5);
            big = ($urandom_range(0, 15) == 0);
            unit = 0;
            for (k = 0; k < nfrag; k++) begin
               hdr.offset = OFF_W'(unit);
               hdr.last = (k == nfrag - 1);
               if (hdr.last) begin
                  hdr.len = big ? LEN_W'($urandom()) : LEN_W'($urandom_range(0, 600));
               end else begin
                  step = big ? $urandom_range(1, 2047) : $urandom_range(1, 64);
                  hdr.len = LEN_W'(8 * step);
                  unit += step;
               end
               hdr.now = wall_seconds;
               wall_seconds += $urandom_range(0, 1);
               pkt.push_back(hdr);
            end
            // damage a share of the packets
            a = $urandom_range(0, pkt.size() - 1);
            b = $urandom_range(0, pkt.size() - 1);
            case ($urandom_range(0, 7))
               0: if (pkt.size() > 1) pkt.delete(a);
               1: pkt.insert(a, pkt[a]);
               2, 3: begin
                  tmp = pkt[a];
                  pkt[a] = pkt[b];
                  pkt[b] = tmp;
               end
               default: ;
            endcase
         end
         foreach (pkt[k]) send_frag(pkt[k], 1'b0, '0);
         sent_here += pkt.size();
         // time moves on, sometimes past the ttl
         if ($urandom_range(0, 9) == 0)
            wall_seconds += $urandom_range(0, 2 * ttl_limit + 2);
      end
   endtask

   // result checker and receiver back-pressure
   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         seen_result.status       = status_type'(rsp_tuser);
         seen_result.slot         = rsp_tdata[2:0];
         seen_result.accepted     = rsp_tdata[3];
         seen_result.write_offset = rsp_tdata[19:4];
         seen_result.total_length = rsp_tdata[36:20];
         results_seen++;
         if (fragment_outcomes.size() == 0) begin
            report_mismatch("result with nothing outstanding, status", 32'(rsp_tuser), '0);
         end else begin
            due_result = fragment_outcomes.pop_front();
            if (seen_result.status !== due_result.status)
               report_mismatch("status", 32'(seen_result.status), 32'(due_result.status));
            if (seen_result.slot !== due_result.slot)
               report_mismatch("slot", 32'(seen_result.slot), 32'(due_result.slot));
            if (seen_result.accepted !== due_result.accepted)
               report_mismatch("accepted", 32'(seen_result.accepted),
                               32'(due_result.accepted));
            if (seen_result.write_offset !== due_result.write_offset)
               report_mismatch("write_offset", 32'(seen_result.write_offset),
                               32'(due_result.write_offset));
            if (seen_result.total_length !== due_result.total_length)
               report_mismatch("total_length", 32'(seen_result.total_length),
                               32'(due_result.total_length));
            if (due_result.status == STATUS_COMPLETE) completions++;
            if (due_result.status == STATUS_NO_SPACE) no_space_count++;
            else if (!due_result.accepted) rejected_count++;
         end
      end
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(8, 64);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         RX_STREAM: rsp_tready <= 1'b1;
         RX_THIRDS: rsp_tready <= (rx_tick % 3 == 0);
         RX_COIN:   rsp_tready <= ($urandom_range(0, 1) != 0);
         default:   rsp_tready <= (rx_tick % 16 >= 11);
      endcase
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, fragment_outcomes.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // main sequence
   initial begin : main_flow
      int                    phase;
      logic [CSR_DATA_W-1:0] ttl_val;
      logic [CSR_DATA_W-1:0] max_val;
      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed rows under reset register values
      foreach (directed_rows[r])
         send_frag(directed_rows[r].hdr, directed_rows[r].pinned, directed_rows[r].want);

      // random traffic under several register settings
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin ttl_val = 32'd3;     max_val = 32'd4096;   end
            1: begin ttl_val = 32'd0;     max_val = 32'd131071; end
            2: begin ttl_val = 32'd65535; max_val = 32'd1;      end
            3: begin ttl_val = 32'd12;    max_val = 32'd65536;  end
            default: begin
               // unused upper bits set at random
               ttl_val = ($urandom() & 32'hFFFF_0000) | $urandom_range(0, 40);
               max_val = ($urandom() & 32'hFFFE_0000) | $urandom_range(1, 131071);
            end
         endcase
         settle();
         write_reg(REG_TTL, ttl_val);
         write_reg(REG_MAX_BYTES, max_val);
         settings_used++;
         wall_seconds = ($urandom_range(0, 1) != 0) ? TIME_W'($urandom())
                                                     : 32'hFFFF_FF00 + $urandom_range(0, 255);
         run_traffic(PHASE_ITEMS);
      end
      settle();

      $display("ran %0d fragment headers under %0d register settings, %0d results checked",
               headers_sent, settings_used, results_seen);
      $display("completions %0d, no-space %0d, rejected payloads %0d, mismatches %0d",
               completions, no_space_count, rejected_count, error_count);
      if (error_count == 0 && fragment_outcomes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: fragment_reassembly_tracker.f
rtl/frt_pkg.sv
rtl/frt_slot_table.sv
rtl/fragment_reassembly_tracker.sv
test/tb_fragment_reassembly_tracker.sv
